FILE: rtl/ccp_pkg.sv
// Shared types and constants for the coefficient compress and pack block.
`timescale 1ns / 1ps
package ccp_pkg;

    localparam int VAL_W  = 9;
    localparam int BITS_W = 4;
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 16;
    localparam int CNT_W  = 5;
    localparam int SH_W   = 3;

    localparam logic [BITS_W-1:0] D_MIN   = 4'd5;
    localparam logic [BITS_W-1:0] D_MAX   = 4'd9;
    localparam logic [BITS_W-1:0] D_RESET = 4'd8;
    localparam logic [VAL_W-1:0]  VAL_MASK = 9'h1ff;
    localparam logic [CNT_W-1:0]  CNT_BYTE = 5'd8;

    localparam logic REG_COEFF_BITS = 1'b0;

    typedef struct packed {
        logic signed [12:0] coefficient;
        logic               last_coefficient;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [BITS_W-1:0] bits;
        logic              last;
    } t_q_entry;

endpackage

FILE: rtl/ccp_front.sv
// Front end: accept coefficients and compress them through a two-stage pipeline.
`timescale 1ns / 1ps
module ccp_front #(
    parameter int MODULUS = 3329,
    parameter int DEPTH   = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ccp_pkg::t_in_word         i_in_word,
    input  logic [ccp_pkg::BITS_W-1:0] i_coeff_bits,
    input  logic [$clog2(DEPTH+1)-1:0] i_q_level,
    output logic                      o_push,
    output ccp_pkg::t_q_entry         o_push_entry
);
    import ccp_pkg::*;

    localparam int QW    = $clog2(MODULUS + 1);
    localparam int UW    = (QW > 12) ? QW : 12;
    localparam int SW    = UW + 2;
    localparam int XW    = UW + VAL_W + 1;
    localparam int K     = XW;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam logic [K-1:0]  RECIP = K'((64'd1 << K) / MODULUS);
    localparam logic [XW-1:0] HALF_Q = XW'(MODULUS / 2);
    localparam logic [XW-1:0] Q_X    = XW'(MODULUS);

    logic                r_s1_valid;
    logic [XW-1:0]       r_s1_x;
    logic [BITS_W-1:0]   r_s1_d;
    logic                r_s1_last;
    logic                r_s2_valid;
    logic [XW+K-1:0]     r_s2_prod;
    logic [XW-1:0]       r_s2_x;
    logic [BITS_W-1:0]   r_s2_d;
    logic                r_s2_last;

    logic                accept;
    logic [LW:0]         busy;
    logic signed [SW-1:0] c_ext;
    logic signed [SW-1:0] c_sum;
    logic [UW-1:0]       u;
    logic [BITS_W-1:0]   d_eff;
    logic [XW-1:0]       x;
    logic [XW-1:0]       q_est;
    logic [XW-1:0]       rem;
    logic [XW-1:0]       t;

    assign busy = (LW+1)'(i_q_level) + (LW+1)'(r_s1_valid) + (LW+1)'(r_s2_valid);
    assign o_in_ready = busy < (LW+1)'(DEPTH);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        c_ext = SW'(i_in_word.coefficient);
        c_sum = c_ext + SW'(MODULUS);
        if (c_ext >= 0) begin
            u = c_ext[UW-1:0];
        end else if (c_sum < 0) begin
            u = '0;
        end else begin
            u = c_sum[UW-1:0];
        end
        if (i_coeff_bits < D_MIN) begin
            d_eff = D_MIN;
        end else if (i_coeff_bits > D_MAX) begin
            d_eff = D_MAX;
        end else begin
            d_eff = i_coeff_bits;
        end
        x = (XW'(u) << d_eff) + HALF_Q;
    end

    always_comb begin
        q_est = r_s2_prod[XW+K-1:K];
        rem   = r_s2_x - XW'(q_est * Q_X);
        t     = (rem >= Q_X) ? q_est + 1'b1 : q_est;
        o_push = r_s2_valid;
        o_push_entry.value = t[VAL_W-1:0] & (VAL_MASK >> (D_MAX - r_s2_d));
        o_push_entry.bits  = r_s2_d;
        o_push_entry.last  = r_s2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_x    <= x;
        r_s1_d    <= d_eff;
        r_s1_last <= i_in_word.last_coefficient;
        r_s2_prod <= (XW+K)'(r_s1_x) * (XW+K)'(RECIP);
        r_s2_x    <= r_s1_x;
        r_s2_d    <= r_s1_d;
        r_s2_last <= r_s1_last;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_x - XW'(r_s2_prod[XW+K-1:K] * Q_X)) < (Q_X << 1))
        else $error("quotient estimate off by more than one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_d >= D_MIN) && (r_s1_d <= D_MAX))
        else $error("bit count escaped clamp");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> busy < (LW+1)'(DEPTH))
        else $error("accepted without queue room");

endmodule

FILE: rtl/ccp_queue.sv
// Small queue between the compress front end and the packer.
`timescale 1ns / 1ps
module ccp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  ccp_pkg::t_q_entry          i_push_entry,
    input  logic                       i_pop,
    output logic                       o_q_valid,
    output ccp_pkg::t_q_entry          o_q_entry,
    output logic [$clog2(DEPTH+1)-1:0] o_q_level
);
    import ccp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    t_q_entry        r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [LW-1:0]   r_level;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;

    assign n_wr_ptr  = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr  = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign o_q_valid = r_level != '0;
    assign o_q_entry = r_mem[r_rd_ptr];
    assign o_q_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level != LW'(DEPTH)) || i_pop)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_level != '0)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers disagree with level");

endmodule

FILE: rtl/ccp_back.sv
// Back end: pack compressed values into bytes and drive the output register.
`timescale 1ns / 1ps
module ccp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ccp_pkg::t_q_entry   i_q_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccp_pkg::t_out_word  o_out_word
);
    import ccp_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0] n_cnt;
    logic             n_last;
    logic [ACC_W-1:0] acc1;
    logic [CNT_W-1:0] cnt1;
    logic             due;
    logic             due1;
    logic             emit;

    always_comb begin
        due  = (r_cnt >= CNT_BYTE) || (r_last && (r_cnt != '0));
        emit = due && (!r_out_valid || i_out_ready);
        if (emit) begin
            acc1 = r_acc >> BYTE_W;
            cnt1 = (r_cnt >= CNT_BYTE) ? r_cnt - CNT_BYTE : '0;
        end else begin
            acc1 = r_acc;
            cnt1 = r_cnt;
        end
        due1  = (cnt1 >= CNT_BYTE) || (r_last && (cnt1 != '0));
        o_pop = !due1 && i_q_valid;
        if (o_pop) begin
            n_acc  = acc1 | (ACC_W'(i_q_entry.value) << cnt1[SH_W-1:0]);
            n_cnt  = cnt1 + CNT_W'(i_q_entry.bits);
            n_last = i_q_entry.last;
        end else begin
            n_acc  = acc1;
            n_cnt  = cnt1;
            n_last = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_last <= n_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_out_word.packed_byte <= r_acc[BYTE_W-1:0];
            r_out_word.last_byte   <= r_last && (r_cnt <= CNT_BYTE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ACC_W))
        else $error("bit count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_last && (r_cnt <= CNT_BYTE) && !o_pop) |=> (r_cnt == '0))
        else $error("buffer not empty after final byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_cnt >= CNT_W'(D_MIN)))
        else $error("value lost on pop");

endmodule

FILE: rtl/coefficient_compress_pack_unit.sv
// Top level: coefficient compress and byte pack unit with APB register port.
`timescale 1ns / 1ps
//  Channel  Direction  Handshake                   Word
//  in       input      i_in_valid / o_in_ready     t_in_word (coefficient, last flag)
//  out      output     o_out_valid / i_out_ready   t_out_word (byte, last flag)
//  cfg      input      psel/penable/pwrite/pready  coeff_bits at byte address 0
//  An accepted coefficient passes the front-end pipeline registers, the queue and the
//  bit buffer on its way to the output register. One coefficient enters per cycle
//  while o_in_ready is high; the one-byte-per-cycle output port sets the sustained rate.
//  Reset is synchronous: it empties queue and bit buffer and sets coeff_bits to 8.
//  A stall on the output fills the queue; ready falls when queue plus pipeline are full.
module coefficient_compress_pack_unit #(
    parameter int MODULUS     = 3329,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccp_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ccp_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [BITS_W-1:0] r_coeff_bits;
    logic              push;
    t_q_entry          push_entry;
    logic              pop;
    logic              q_valid;
    t_q_entry          q_entry;
    logic [LW-1:0]     q_level;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COEFF_BITS) ? 32'(r_coeff_bits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_bits <= D_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COEFF_BITS)) begin
            r_coeff_bits <= pwdata[BITS_W-1:0];
        end
    end

    ccp_front #(
        .MODULUS (MODULUS),
        .DEPTH   (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_coeff_bits (r_coeff_bits),
        .i_q_level    (q_level),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    ccp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_q_valid    (q_valid),
        .o_q_entry    (q_entry),
        .o_q_level    (q_level)
    );

    ccp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
